// ===== sv/nvbf_pkg.sv =====
// ----------------------------------------------------------------------------
// nvbf_pkg
// Shared types and constants for the NBT value boundary finder.
// ----------------------------------------------------------------------------
`default_nettype none

package nvbf_pkg;

    localparam logic [3:0] TAG_END   = 4'd0;
    localparam logic [3:0] TAG_BYTES = 4'd7;
    localparam logic [3:0] TAG_STR   = 4'd8;
    localparam logic [3:0] TAG_SEQ   = 4'd9;
    localparam logic [3:0] TAG_GROUP = 4'd10;
    localparam logic [3:0] TAG_INTS  = 4'd11;
    localparam logic [3:0] TAG_LONGS = 4'd12;
    localparam logic [3:0] TAG_BAD   = 4'd15;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_MARKER    = 4'd1,
        PH_ROOT      = 4'd2,
        PH_CHILD     = 4'd3,
        PH_NAME_LEN  = 4'd4,
        PH_NAME_SKIP = 4'd5,
        PH_STR_LEN   = 4'd6,
        PH_ARR_LEN   = 4'd7,
        PH_LIST_ELEM = 4'd8,
        PH_LIST_LEN  = 4'd9,
        PH_SKIP      = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        ST_MORE    = 3'd0,
        ST_DONE    = 3'd1,
        ST_INVALID = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_DEEP    = 3'd4,
        ST_OUTSIDE = 3'd5
    } t_status;

    // one open compound or list
    typedef struct packed {
        logic        is_list;
        logic [3:0]  tag;
        logic [31:0] left;
    } t_frame;

    // one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } t_item;

    // one result
    typedef struct packed {
        logic [2:0]  status;
        logic        present;
        logic [31:0] consumed;
    } t_result;

    // payload bytes of the fixed-width scalar tags
    function automatic logic [35:0] fixed_size(input logic [3:0] tag);
        logic [35:0] r;
        unique case (tag)
            4'd1:    r = 36'd1;
            4'd2:    r = 36'd2;
            4'd3:    r = 36'd4;
            4'd4:    r = 36'd8;
            4'd5:    r = 36'd4;
            4'd6:    r = 36'd8;
            default: r = 36'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/nvbf_in_stage.sv =====
// ----------------------------------------------------------------------------
// nvbf_in_stage
// Input register: holds one accepted request until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nvbf_in_stage
    import nvbf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // hold the request until the core consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nvbf_out_stage.sv =====
// ----------------------------------------------------------------------------
// nvbf_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nvbf_out_stage
    import nvbf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // load a new result or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nvbf_core.sv =====
// ----------------------------------------------------------------------------
// nvbf_core
// Parse state and frame stack; advances one byte per cycle while i_step is high.
// Lists on their last element leave the physical stack and are kept as a
// count of pending levels above the frame below them, so a completion
// unwinds any number of finished lists in one step.
// ----------------------------------------------------------------------------
`default_nettype none

module nvbf_core
    import nvbf_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_marker_en,
    input  wire logic  i_step,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_tag, n_tag;
    logic [31:0] r_lshift, n_lshift;
    logic [35:0] r_skip, n_skip;
    logic [31:0] r_total, n_total;
    logic [LW-1:0] r_level, n_level;
    logic [LW-1:0] r_sp, n_sp;
    logic [LW-1:0] r_tail0, n_tail0;
    t_frame        r_frm  [STACK_DEPTH];
    t_frame        n_frm  [STACK_DEPTH];
    logic [LW-1:0] r_tail [STACK_DEPTH];
    logic [LW-1:0] n_tail [STACK_DEPTH];

    // byte step
    always_comb begin
        t_status     st;
        logic        pres;
        logic        do_cmp;
        logic        do_start;
        logic [3:0]  stag;
        logic [7:0]  b;
        logic [35:0] n;
        logic [31:0] left;
        logic [IW-1:0] top;

        n_phase  = r_phase;
        n_tag    = r_tag;
        n_lshift = r_lshift;
        n_skip   = r_skip;
        n_total  = r_total;
        n_level  = r_level;
        n_sp     = r_sp;
        n_tail0  = r_tail0;
        n_frm    = r_frm;
        n_tail   = r_tail;
        st       = ST_MORE;
        pres     = 1'b1;
        do_cmp   = 1'b0;
        do_start = 1'b0;
        stag     = r_tag;
        b        = i_item.data_byte;
        n        = '0;
        left     = '0;
        top      = '0;

        // restart on a first byte
        if (i_item.first) begin
            n_level  = '0;
            n_sp     = '0;
            n_tail0  = '0;
            n_tag    = '0;
            n_lshift = '0;
            n_skip   = '0;
            n_total  = '0;
            n_phase  = i_marker_en ? PH_MARKER : PH_ROOT;
        end

        if (n_phase == PH_IDLE) begin
            st = ST_OUTSIDE;
        end else begin
            if (n_total != 32'hFFFF_FFFF) begin
                n_total = n_total + 32'd1;
            end

            // decode the byte by phase
            unique case (n_phase)
                PH_MARKER, PH_ROOT: begin
                    if (n_phase == PH_MARKER && b == 8'd1) begin
                        n_phase = PH_ROOT;
                    end else if (b == 8'd0) begin
                        pres = 1'b0;
                        st   = ST_DONE;
                    end else if (b > 8'(TAG_LONGS)) begin
                        st = ST_INVALID;
                    end else begin
                        do_start = 1'b1;
                        stag     = b[3:0];
                    end
                end
                PH_CHILD: begin
                    if (b == 8'(TAG_END)) begin
                        n_sp    = n_sp - LW'(1);
                        n_level = n_level - LW'(1);
                        do_cmp  = 1'b1;
                    end else if (b > 8'(TAG_LONGS)) begin
                        st = ST_TRUNC;
                    end else begin
                        n_tag    = b[3:0];
                        n_lshift = '0;
                        n_skip   = 36'd2;
                        n_phase  = PH_NAME_LEN;
                    end
                end
                PH_NAME_LEN: begin
                    n_lshift = {n_lshift[23:0], b};
                    n_skip   = n_skip - 36'd1;
                    if (n_skip == '0) begin
                        if (n_lshift == '0) begin
                            do_start = 1'b1;
                            stag     = n_tag;
                        end else begin
                            n_skip  = {4'd0, n_lshift};
                            n_phase = PH_NAME_SKIP;
                        end
                    end
                end
                PH_NAME_SKIP: begin
                    n_skip = n_skip - 36'd1;
                    if (n_skip == '0) begin
                        do_start = 1'b1;
                        stag     = n_tag;
                    end
                end
                PH_STR_LEN, PH_ARR_LEN: begin
                    n_lshift = {n_lshift[23:0], b};
                    n_skip   = n_skip - 36'd1;
                    if (n_skip == '0) begin
                        n = {4'd0, n_lshift};
                        if (n_phase == PH_ARR_LEN && n_tag == TAG_INTS) begin
                            n = n << 2;
                        end else if (n_phase == PH_ARR_LEN && n_tag == TAG_LONGS) begin
                            n = n << 3;
                        end
                        if (n == '0) begin
                            do_cmp = 1'b1;
                        end else begin
                            n_skip  = n;
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_LIST_ELEM: begin
                    n_tag    = (b <= 8'(TAG_LONGS)) ? b[3:0] : TAG_BAD;
                    n_lshift = '0;
                    n_skip   = 36'd4;
                    n_phase  = PH_LIST_LEN;
                end
                PH_LIST_LEN: begin
                    n_lshift = {n_lshift[23:0], b};
                    n_skip   = n_skip - 36'd1;
                    if (n_skip == '0) begin
                        if (n_lshift == '0) begin
                            do_cmp = 1'b1;
                        end else if (n_level >= LW'(STACK_DEPTH)) begin
                            st = ST_DEEP;
                        end else begin
                            if (n_lshift == 32'd1) begin
                                // single element: count the level as pending only
                                if (n_sp == '0) begin
                                    n_tail0 = n_tail0 + LW'(1);
                                end else begin
                                    top         = IW'(n_sp - LW'(1));
                                    n_tail[top] = n_tail[top] + LW'(1);
                                end
                            end else begin
                                top                 = IW'(n_sp);
                                n_frm[top].is_list  = 1'b1;
                                n_frm[top].tag      = n_tag;
                                n_frm[top].left     = n_lshift;
                                n_tail[top]         = '0;
                                n_sp                = n_sp + LW'(1);
                            end
                            n_level  = n_level + LW'(1);
                            do_start = 1'b1;
                            stag     = n_tag;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = n_skip - 36'd1;
                    if (n_skip == '0) begin
                        do_cmp = 1'b1;
                    end
                end
                default: begin
                    st = ST_OUTSIDE;
                end
            endcase

            // finish a payload: unwind pending lists, then resume the top frame
            if (do_cmp) begin
                if (n_sp == '0) begin
                    n_level = '0;
                    n_tail0 = '0;
                    st      = ST_DONE;
                end else begin
                    top         = IW'(n_sp - LW'(1));
                    n_level     = n_level - n_tail[top];
                    n_tail[top] = '0;
                    if (!n_frm[top].is_list) begin
                        n_phase = PH_CHILD;
                    end else begin
                        left     = n_frm[top].left - 32'd1;
                        do_start = 1'b1;
                        stag     = n_frm[top].tag;
                        if (left == 32'd1) begin
                            // last element: drop the frame, keep the level pending
                            n_sp = n_sp - LW'(1);
                            if (n_sp == '0) begin
                                n_tail0 = n_tail0 + LW'(1);
                            end else begin
                                top         = IW'(n_sp - LW'(1));
                                n_tail[top] = n_tail[top] + LW'(1);
                            end
                        end else begin
                            n_frm[top].left = left;
                        end
                    end
                end
            end

            // open the payload of a tag
            if (do_start) begin
                unique case (stag)
                    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
                        n_skip  = fixed_size(stag);
                        n_phase = PH_SKIP;
                    end
                    TAG_BYTES, TAG_INTS, TAG_LONGS: begin
                        n_tag    = stag;
                        n_lshift = '0;
                        n_skip   = 36'd4;
                        n_phase  = PH_ARR_LEN;
                    end
                    TAG_STR: begin
                        n_lshift = '0;
                        n_skip   = 36'd2;
                        n_phase  = PH_STR_LEN;
                    end
                    TAG_SEQ: begin
                        n_phase = PH_LIST_ELEM;
                    end
                    TAG_GROUP: begin
                        if (n_level >= LW'(STACK_DEPTH)) begin
                            st = ST_DEEP;
                        end else begin
                            top                = IW'(n_sp);
                            n_frm[top].is_list = 1'b0;
                            n_frm[top].tag     = '0;
                            n_frm[top].left    = '0;
                            n_tail[top]        = '0;
                            n_sp               = n_sp + LW'(1);
                            n_level            = n_level + LW'(1);
                            n_phase            = PH_CHILD;
                        end
                    end
                    default: begin
                        st = ST_TRUNC;
                    end
                endcase
            end

            if (st == ST_MORE && i_item.last) begin
                st = ST_TRUNC;
            end
            if (st != ST_MORE) begin
                n_phase = PH_IDLE;
            end
        end

        o_result.status   = st;
        o_result.present  = (st == ST_DONE) && pres;
        o_result.consumed = (st == ST_OUTSIDE) ? 32'd0 : n_total;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_level <= '0;
            r_sp    <= '0;
            r_tail0 <= '0;
            r_tag   <= '0;
            r_total <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_level <= n_level;
            r_sp    <= n_sp;
            r_tail0 <= n_tail0;
            r_tag   <= n_tag;
            r_total <= n_total;
        end
    end

    // counters and frame store
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_lshift <= n_lshift;
            r_skip   <= n_skip;
            r_frm    <= n_frm;
            r_tail   <= n_tail;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nbt_value_boundary_finder_top.sv =====
// ----------------------------------------------------------------------------
// nbt_value_boundary_finder_top
// Finds the end of one big-endian NBT value in a byte stream.
//
//   channel  direction  handshake                   payload
//   in       in         i_in_valid / o_in_ready     i_data_byte, i_first, i_last
//   out      out        o_out_valid / i_out_ready   o_status, o_present, o_consumed
//   cfg      in         i_cfg_valid / o_cfg_ready   i_cfg_optional_marker
//
// One byte per cycle while the output is not stalled: a request is registered in
// the input register when accepted, parsed by the core once the output register has
// room, and its result is then loaded into the output register.
// The parse of one byte is a single pass over the top stack frame.
// A stalled output holds the parse; new requests wait in the input register.
// Reset clears the parse control state, not the counters or frame store; the block starts outside any value.
// ----------------------------------------------------------------------------
`default_nettype none

module nbt_value_boundary_finder_top
    import nvbf_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic             o_present,
    output logic [31:0]      o_consumed,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_optional_marker
);

    logic    r_marker_en;
    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_space;
    logic    step;
    t_result core_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;

    // hold the marker mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_en <= 1'b0;
        end else if (i_cfg_valid) begin
            r_marker_en <= i_cfg_optional_marker;
        end
    end

    assign in_item.data_byte = i_data_byte;
    assign in_item.first     = i_first;
    assign in_item.last      = i_last;

    // advance when a request is held and the result register has room
    assign step = held_valid && out_space;

    nvbf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    nvbf_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_marker_en (r_marker_en),
        .i_step      (step),
        .i_item      (held_item),
        .o_result    (core_result)
    );

    nvbf_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .o_space  (out_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_status   = out_result.status;
    assign o_present  = out_result.present;
    assign o_consumed = out_result.consumed;

endmodule

`default_nettype wire

// ===== dv/nbt_value_boundary_finder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nbt_value_boundary_finder_top_tb
// Drives byte requests carrying NBT values (well formed, broken and noise)
// through the boundary finder. Every result is checked against a behavioral
// parser, and directed rows marked known also against typed-in values.
// ----------------------------------------------------------------------------
`default_nettype none

module nbt_value_boundary_finder_top_tb;
    import nvbf_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 550;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_first;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic        o_present;
    logic [31:0] o_consumed;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_optional_marker;

    nbt_value_boundary_finder_top #(.STACK_DEPTH(DEPTH)) uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_data_byte           (i_data_byte),
        .i_first               (i_first),
        .i_last                (i_last),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_status              (o_status),
        .o_present             (o_present),
        .o_consumed            (o_consumed),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_optional_marker (i_cfg_optional_marker)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // parser model state
    t_frame      nest_stack [DEPTH];
    int unsigned nest_level;
    t_phase      phase;
    logic [3:0]  pend_tag;
    logic [31:0] len_acc;
    logic [35:0] bytes_left;
    logic [31:0] value_len;
    logic        marker_mode;

    t_result     result_q [$];
    int          fail_count;
    int          cycle_count;
    int          items_sent;
    bit          hold_off;

    task automatic parser_reset();
        nest_level = 0;
        phase      = PH_IDLE;
        pend_tag   = '0;
        len_acc    = '0;
        bytes_left = '0;
        value_len  = '0;
        marker_mode = 1'b0;
    endtask

    function automatic logic [35:0] scalar_bytes(logic [3:0] tag);
        case (tag)
            4'd1: return 36'd1;
            4'd2: return 36'd2;
            4'd3: return 36'd4;
            4'd4: return 36'd8;
            4'd5: return 36'd4;
            default: return 36'd8;
        endcase
    endfunction

    function automatic t_status open_payload(logic [3:0] tag);
        if (tag >= 4'd1 && tag <= 4'd6) begin
            bytes_left = scalar_bytes(tag);
            phase = PH_SKIP;
            return ST_MORE;
        end
        case (tag)
            TAG_BYTES, TAG_INTS, TAG_LONGS: begin
                pend_tag = tag;
                len_acc = '0;
                bytes_left = 36'd4;
                phase = PH_ARR_LEN;
                return ST_MORE;
            end
            TAG_STR: begin
                len_acc = '0;
                bytes_left = 36'd2;
                phase = PH_STR_LEN;
                return ST_MORE;
            end
            TAG_SEQ: begin
                phase = PH_LIST_ELEM;
                return ST_MORE;
            end
            TAG_GROUP: begin
                if (nest_level >= DEPTH) return ST_DEEP;
                nest_stack[nest_level] = '0;
                nest_level++;
                phase = PH_CHILD;
                return ST_MORE;
            end
            default: return ST_TRUNC;
        endcase
    endfunction

    // unwind finished lists, then continue or finish
    function automatic t_status close_payload();
        t_frame top;
        while (nest_level > 0) begin
            top = nest_stack[nest_level-1];
            if (!top.is_list) begin
                phase = PH_CHILD;
                return ST_MORE;
            end
            top.left = top.left - 32'd1;
            if (top.left == 32'd0) begin
                nest_level--;
                continue;
            end
            nest_stack[nest_level-1] = top;
            return open_payload(top.tag);
        end
        return ST_DONE;
    endfunction

    function automatic t_status root_byte(logic [7:0] b, ref logic pres);
        if (b == 8'(TAG_END)) begin
            pres = 1'b0;
            return ST_DONE;
        end
        if (b > 8'(TAG_LONGS)) return ST_INVALID;
        return open_payload(b[3:0]);
    endfunction

    function automatic bit take_len(logic [7:0] b);
        len_acc = {len_acc[23:0], b};
        bytes_left = bytes_left - 36'd1;
        return bytes_left == 36'd0;
    endfunction

    function automatic t_status parse_byte(logic [7:0] b, ref logic pres);
        logic [35:0] n;
        case (phase)
            PH_MARKER: begin
                if (b == 8'd0) begin
                    pres = 1'b0;
                    return ST_DONE;
                end
                if (b == 8'd1) begin
                    phase = PH_ROOT;
                    return ST_MORE;
                end
                return root_byte(b, pres);
            end
            PH_ROOT: return root_byte(b, pres);
            PH_CHILD: begin
                if (b == 8'(TAG_END)) begin
                    nest_level--;
                    return close_payload();
                end
                if (b > 8'(TAG_LONGS)) return ST_TRUNC;
                pend_tag = b[3:0];
                len_acc = '0;
                bytes_left = 36'd2;
                phase = PH_NAME_LEN;
                return ST_MORE;
            end
            PH_NAME_LEN: begin
                if (!take_len(b)) return ST_MORE;
                if (len_acc == 32'd0) return open_payload(pend_tag);
                bytes_left = {4'd0, len_acc};
                phase = PH_NAME_SKIP;
                return ST_MORE;
            end
            PH_NAME_SKIP: begin
                bytes_left = bytes_left - 36'd1;
                return bytes_left == 36'd0 ? open_payload(pend_tag) : ST_MORE;
            end
            PH_STR_LEN, PH_ARR_LEN: begin
                if (!take_len(b)) return ST_MORE;
                n = {4'd0, len_acc};
                if (phase == PH_ARR_LEN) begin
                    if (pend_tag == TAG_INTS) n = n << 2;
                    else if (pend_tag == TAG_LONGS) n = n << 3;
                end
                if (n == 36'd0) return close_payload();
                bytes_left = n;
                phase = PH_SKIP;
                return ST_MORE;
            end
            PH_LIST_ELEM: begin
                pend_tag = (b <= 8'(TAG_LONGS)) ? b[3:0] : TAG_BAD;
                len_acc = '0;
                bytes_left = 36'd4;
                phase = PH_LIST_LEN;
                return ST_MORE;
            end
            PH_LIST_LEN: begin
                if (!take_len(b)) return ST_MORE;
                if (len_acc == 32'd0) return close_payload();
                if (nest_level >= DEPTH) return ST_DEEP;
                nest_stack[nest_level] = '{is_list: 1'b1, tag: pend_tag, left: len_acc};
                nest_level++;
                return open_payload(pend_tag);
            end
            PH_SKIP: begin
                bytes_left = bytes_left - 36'd1;
                return bytes_left == 36'd0 ? close_payload() : ST_MORE;
            end
            default: return ST_OUTSIDE;
        endcase
    endfunction

    function automatic t_result predict_result(logic [7:0] b, logic f, logic l);
        t_result r;
        logic    pres;
        t_status st;
        pres = 1'b1;
        if (f) begin
            nest_level = 0;
            pend_tag = '0;
            len_acc = '0;
            bytes_left = '0;
            value_len = '0;
            phase = marker_mode ? PH_MARKER : PH_ROOT;
        end
        if (phase == PH_IDLE) begin
            r = '{status: ST_OUTSIDE, present: 1'b0, consumed: 32'd0};
            return r;
        end
        if (value_len != 32'hFFFF_FFFF) value_len++;
        st = parse_byte(b, pres);
        if (st == ST_MORE && l) st = ST_TRUNC;
        if (st != ST_MORE) phase = PH_IDLE;
        r.status = st;
        r.present = (st == ST_DONE) && pres;
        r.consumed = value_len;
        return r;
    endfunction

    // send one request; valid stays high into the next request when no idle
    task automatic send_byte(logic [7:0] b, logic f, logic l,
                             bit known = 0, t_status k_st = ST_MORE,
                             logic k_pres = 0, logic [31:0] k_len = 0);
        t_result r;
        int      gap;
        gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r = predict_result(b, f, l);
        if (known && (r.status != k_st || r.present != k_pres || r.consumed != k_len)) begin
            $error("status/present/consumed: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                   k_st, k_pres, k_len, r.status, r.present, r.consumed);
            fail_count++;
        end
        result_q.push_back(r);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_first     <= f;
        i_last      <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // drop the request, wait for drain, then write the marker register
    task automatic write_marker(logic v);
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_optional_marker <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        marker_mode = v;
    endtask

    task automatic send_seq(byte unsigned s[$], bit brk);
        int cut;
        cut = brk ? int'($urandom_range(0, s.size() - 1)) : s.size() - 1;
        for (int i = 0; i <= cut; i++) begin
            if (items_sent >= ITEM_TARGET) break;
            send_byte(s[i], i == 0, (i == cut) && ($urandom_range(0, 3) == 0));
        end
    endtask

    // random well-formed payload of a tag
    function automatic void gen_payload(ref byte unsigned s[$], input int tag, int lvl);
        int n;
        int et;
        case (tag)
            1, 2, 3, 4, 5, 6: repeat (int'(scalar_bytes(tag[3:0]))) s.push_back(8'($urandom));
            TAG_BYTES, TAG_INTS, TAG_LONGS: begin
                n = $urandom_range(0, 3);
                s.push_back(8'd0); s.push_back(8'd0); s.push_back(8'd0); s.push_back(8'(n));
                repeat (n * (tag == TAG_BYTES ? 1 : tag == TAG_INTS ? 4 : 8))
                    s.push_back(8'($urandom));
            end
            TAG_STR: begin
                n = $urandom_range(0, 4);
                s.push_back(8'd0); s.push_back(8'(n));
                repeat (n) s.push_back(8'($urandom));
            end
            TAG_SEQ: begin
                et = (lvl > 3) ? $urandom_range(1, 8) : $urandom_range(1, 12);
                n = $urandom_range(0, 3);
                s.push_back(8'(et));
                s.push_back(8'd0); s.push_back(8'd0); s.push_back(8'd0); s.push_back(8'(n));
                repeat (n) gen_payload(s, et, lvl + 1);
            end
            default: begin
                n = (lvl > 3) ? 0 : $urandom_range(0, 3);
                repeat (n) begin
                    et = $urandom_range(1, 12);
                    s.push_back(8'(et));
                    s.push_back(8'd0);
                    s.push_back(8'($urandom_range(0, 2)));
                    repeat (s[s.size()-1]) s.push_back(8'($urandom));
                    gen_payload(s, et, lvl + 1);
                end
                s.push_back(8'(TAG_END));
            end
        endcase
    endfunction

    typedef struct {
        logic [7:0]  b;
        logic        f;
        logic        l;
        bit          known;
        t_status     st;
        logic        pres;
        logic [31:0] len;
    } t_row;

    t_row rows [$];

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $error("result with no expectation waiting");
                fail_count++;
            end else begin
                e = result_q.pop_front();
                if (o_status != e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    fail_count++;
                end
                if (o_present != e.present) begin
                    $error("present: expected %0d actual %0d", e.present, o_present);
                    fail_count++;
                end
                if (o_consumed != e.consumed) begin
                    $error("consumed: expected %0d actual %0d", e.consumed, o_consumed);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (i_out_ready && o_out_valid) begin
                gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 17)) : 0;
                if (gap != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // long receiver hold-off while requests keep coming
    initial begin
        hold_off = 1'b0;
        wait (items_sent > 250);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        byte unsigned s[$];
        int seq;
        int kind;
        fail_count = 0;
        cycle_count = 0;
        items_sent = 0;
        parser_reset();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_first = 1'b0;
        i_last = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_optional_marker = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: outside, end root, invalid root, byte value, truncation, list cases
        rows = '{
            '{8'hFF, 0, 0, 1, ST_OUTSIDE, 0, 0},
            '{8'h00, 1, 0, 1, ST_DONE,    0, 1},
            '{8'h00, 0, 0, 1, ST_OUTSIDE, 0, 0},
            '{8'hFF, 1, 0, 1, ST_INVALID, 0, 1},
            '{8'h0D, 1, 0, 1, ST_INVALID, 0, 1},
            '{8'h01, 1, 0, 1, ST_MORE,    0, 1},
            '{8'hFF, 0, 0, 1, ST_DONE,    1, 2},
            '{8'h03, 1, 0, 1, ST_MORE,    0, 1},
            '{8'h00, 0, 1, 1, ST_TRUNC,   0, 2},
            '{8'h0A, 1, 0, 1, ST_MORE,    0, 1},
            '{8'h0D, 0, 0, 1, ST_TRUNC,   0, 2},
            '{8'h09, 1, 0, 0, ST_MORE, 0, 0},
            '{8'h00, 0, 0, 0, ST_MORE, 0, 0},
            '{8'h00, 0, 0, 0, ST_MORE, 0, 0},
            '{8'h00, 0, 0, 0, ST_MORE, 0, 0},
            '{8'h00, 0, 0, 0, ST_MORE, 0, 0},
            '{8'h01, 0, 0, 0, ST_MORE, 0, 0},
            '{8'h09, 1, 0, 0, ST_MORE, 0, 0},
            '{8'hFF, 0, 0, 0, ST_MORE, 0, 0},
            '{8'hFF, 0, 0, 0, ST_MORE, 0, 0},
            '{8'hFF, 0, 0, 0, ST_MORE, 0, 0},
            '{8'hFF, 0, 0, 0, ST_MORE, 0, 0},
            '{8'hFF, 0, 1, 0, ST_MORE, 0, 0}
        };
        foreach (rows[i])
            send_byte(rows[i].b, rows[i].f, rows[i].l, rows[i].known,
                      rows[i].st, rows[i].pres, rows[i].len);

        // stack overflow: nested compounds past the depth
        send_byte(8'(TAG_GROUP), 1, 0);
        for (int i = 0; i < DEPTH; i++) begin
            send_byte(8'(TAG_GROUP), 0, 0);
            send_byte(8'h00, 0, 0);
            send_byte(8'h00, 0, 0);
        end

        // marker mode directed
        write_marker(1'b1);
        send_byte(8'h00, 1, 0, 1, ST_DONE, 0, 1);
        send_byte(8'h01, 1, 0, 1, ST_MORE, 0, 1);
        send_byte(8'h00, 0, 0, 1, ST_DONE, 0, 2);
        send_byte(8'hFE, 1, 0, 1, ST_INVALID, 0, 1);
        write_marker(1'b0);

        // random part, switching the marker setting every few values
        seq = 0;
        while (items_sent < ITEM_TARGET) begin
            if (seq != 0 && seq % 18 == 0) write_marker(~marker_mode);
            s.delete();
            kind = $urandom_range(0, 9);
            if (marker_mode && $urandom_range(0, 1)) s.push_back(8'($urandom_range(0, 1)));
            if (kind < 7) begin
                s.push_back(8'($urandom_range(0, 12)));
                gen_payload(s, s[s.size()-1], 0);
                send_seq(s, kind == 6);
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 8)) s.push_back(8'($urandom));
                send_seq(s, 0);
            end else begin
                send_byte(8'($urandom), 0, 1'($urandom_range(0, 1)));
            end
            seq++;
        end
        i_in_valid <= 1'b0;

        // drain
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
